// ===== src/hsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared widths, codes and position helpers for the Hamming SEC codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam int WORD_W            = 63;
	localparam int POS_W             = 6;
	localparam int LEN_W             = 6;
	localparam int STATUS_W          = 2;
	localparam int DATA_MAX          = 57;
	localparam int MAX_DATA_BITS_DEF = 57;
	localparam logic [LEN_W-1:0] DATA_LEN_RESET = 6'd57;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_CORRECTED = 2'd1,
		ST_BEYOND    = 2'd2
	} status_t;

	typedef struct packed {
		logic [POS_W-1:0] error_position;
		status_t          status;
	} dec_info_t;

	function automatic logic is_pow2(input int p);
		return (p & (p - 1)) == 0;
	endfunction

	// Number of data positions below position p (positions count from 1).
	function automatic logic [POS_W-1:0] data_idx(input int p);
		int cnt;
		cnt = 0;
		for (int q = 1; q < p; q++) begin
			if (!is_pow2(q)) cnt++;
		end
		return POS_W'(cnt);
	endfunction

	// Codeword position of data bit k.
	function automatic logic [POS_W-1:0] data_pos(input int k);
		int found;
		found = WORD_W;
		for (int p = WORD_W; p >= 1; p--) begin
			if (!is_pow2(p) && (data_idx(p) == POS_W'(k))) found = p;
		end
		return POS_W'(found);
	endfunction

endpackage

// ===== src/hsc_cfg.sv =====
// ----------------------------------------------------------------------------
// hsc_cfg
// Data length register and its clamp to the supported range.
// ----------------------------------------------------------------------------
module hsc_cfg #(
	parameter int MaxDataBits = hsc_pkg::MAX_DATA_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [hsc_pkg::LEN_W-1:0] wr_data,
	output logic [hsc_pkg::LEN_W-1:0] eff_len
);
	import hsc_pkg::*;

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxDataBits);

	logic [LEN_W-1:0] data_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_len_q <= DATA_LEN_RESET;
		end else if (wr_en) begin
			data_len_q <= wr_data;
		end
	end

	// A length of zero behaves as one; anything above the maximum is capped.
	always_comb begin
		if (data_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (data_len_q > MaxLen) begin
			eff_len = MaxLen;
		end else begin
			eff_len = data_len_q;
		end
	end

endmodule

// ===== src/hsc_enc.sv =====
// ----------------------------------------------------------------------------
// hsc_enc
// Scatters data bits to non-power-of-two positions and adds even parity.
// ----------------------------------------------------------------------------
module hsc_enc (
	input  logic [hsc_pkg::LEN_W-1:0]  eff_len,
	input  logic [hsc_pkg::WORD_W-1:0] data,
	output logic [hsc_pkg::WORD_W-1:0] codeword
);
	import hsc_pkg::*;

	logic [POS_W-1:0] syn;

	always_comb begin
		codeword = '0;
		syn      = '0;
		for (int k = 0; k < DATA_MAX; k++) begin
			if ((LEN_W'(k) < eff_len) && data[k]) begin
				codeword[data_pos(k) - 6'd1] = 1'b1;
				syn ^= data_pos(k);
			end
		end
		// Each syndrome bit becomes the parity bit at the matching power of two.
		for (int j = 0; j < POS_W; j++) begin
			codeword[POS_W'((1 << j) - 1)] = syn[j];
		end
	end

endmodule

// ===== src/hsc_dec.sv =====
// ----------------------------------------------------------------------------
// hsc_dec
// Forms the syndrome, corrects a single bit and extracts the data bits.
// ----------------------------------------------------------------------------
module hsc_dec (
	input  logic [hsc_pkg::LEN_W-1:0]  eff_len,
	input  logic [hsc_pkg::WORD_W-1:0] codeword,
	output logic [hsc_pkg::WORD_W-1:0] data,
	output hsc_pkg::dec_info_t         info
);
	import hsc_pkg::*;

	logic [WORD_W-1:0] in_code;
	logic [WORD_W-1:0] fixed;
	logic [POS_W-1:0]  syn;
	status_t           stat;

	// A position lies inside the code when some used data bit sits at or above it.
	always_comb begin
		for (int p = 1; p <= WORD_W; p++) begin
			in_code[p-1] = data_idx(p) < eff_len;
		end
	end

	always_comb begin
		syn = '0;
		for (int p = 1; p <= WORD_W; p++) begin
			if (in_code[p-1] && codeword[p-1]) syn ^= POS_W'(p);
		end
	end

	always_comb begin
		fixed = codeword;
		stat  = ST_OK;
		if (syn != '0) begin
			if (in_code[syn - 6'd1]) begin
				fixed[syn - 6'd1] = ~codeword[syn - 6'd1];
				stat = ST_CORRECTED;
			end else begin
				stat = ST_BEYOND;
			end
		end
	end

	always_comb begin
		data = '0;
		for (int k = 0; k < DATA_MAX; k++) begin
			data[k] = fixed[data_pos(k) - 6'd1] & (LEN_W'(k) < eff_len);
		end
	end

	assign info.error_position = syn;
	assign info.status         = stat;

endmodule

// ===== src/hamming_sec_codec.sv =====
// ----------------------------------------------------------------------------
// hamming_sec_codec
// Single-error-correcting Hamming encoder and decoder with a settable length.
// A result strobes on done once its request has passed the input register and the result register.
// Throughput: one request per cycle; busy stays low, so start is always taken.
// The input register and the result register bound one XOR network per pass.
// Reset clears the pipeline valid flags and sets the data length to 57.
// ----------------------------------------------------------------------------
module hamming_sec_codec #(
	parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        data_len_wr_en,
	input  logic [hsc_pkg::LEN_W-1:0]    data_len_wr_data,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [hsc_pkg::WORD_W-1:0]   word,
	output logic                        done,
	output logic [hsc_pkg::WORD_W-1:0]   result_word,
	output logic [hsc_pkg::POS_W-1:0]    error_position,
	output logic [hsc_pkg::STATUS_W-1:0] status
);
	import hsc_pkg::*;

	logic              valid_s1;
	logic              func_s1;
	logic [WORD_W-1:0] word_s1;
	logic              valid_s2;
	logic [WORD_W-1:0] result_s2;
	dec_info_t         info_s2;
	logic [LEN_W-1:0]  eff_len;
	logic [WORD_W-1:0] enc_word;
	logic [WORD_W-1:0] dec_word;
	dec_info_t         dec_info;
	logic              accept;

	// The codec takes a new request every cycle, so it never pushes back.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	hsc_cfg #(
		.MaxDataBits(MAX_DATA_BITS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (data_len_wr_en),
		.wr_data(data_len_wr_data),
		.eff_len(eff_len)
	);

	hsc_enc u_enc (
		.eff_len (eff_len),
		.data    (word_s1),
		.codeword(enc_word)
	);

	hsc_dec u_dec (
		.eff_len (eff_len),
		.codeword(word_s1),
		.data    (dec_word),
		.info    (dec_info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			word_s1 <= word;
		end
		if (valid_s1) begin
			if (func_s1 == FUNC_DECODE) begin
				result_s2 <= dec_word;
				info_s2   <= dec_info;
			end else begin
				result_s2              <= enc_word;
				info_s2.error_position <= '0;
				info_s2.status         <= ST_OK;
			end
		end
	end

	assign done           = valid_s2;
	assign result_word    = result_s2;
	assign error_position = info_s2.error_position;
	assign status         = info_s2.status;

`ifndef NO_ASSERTIONS
	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted request produced no result");

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result without a request");

	a_ok_means_no_position: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OK) |-> error_position == '0)
		else $error("clean status with a nonzero error position");

	a_error_has_position: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_CORRECTED || status == ST_BEYOND)) |->
		error_position != '0)
		else $error("error status with a zero error position");
`endif

endmodule

// ===== test/tb_hamming_sec_codec.sv =====
// ----------------------------------------------------------------------------
// tb_hamming_sec_codec
// Self-checking bench for the Hamming SEC codec. Requests are encode and decode
// words under several data lengths. A local predictor computes each expected
// codeword, syndrome and status. Every strobed result is compared in order.
// ----------------------------------------------------------------------------
module tb_hamming_sec_codec;
	timeunit 1ns;
	timeprecision 1ps;

	import hsc_pkg::*;

	localparam int MAX_BITS = MAX_DATA_BITS_DEF;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [POS_W-1:0]  pos;
		status_t           st;
	} codec_result_t;

	logic                clk;
	logic                arst_n;
	logic                data_len_wr_en;
	logic [LEN_W-1:0]    data_len_wr_data;
	logic                start;
	logic                busy;
	logic                func;
	logic [WORD_W-1:0]   word;
	logic                done;
	logic [WORD_W-1:0]   result_word;
	logic [POS_W-1:0]    error_position;
	logic [STATUS_W-1:0] status;

	codec_result_t    expected_q[$];
	logic [LEN_W-1:0] data_len_model = DATA_LEN_RESET;
	logic [LEN_W-1:0] cur_len = DATA_LEN_RESET;
	bit               no_gaps = 0;
	int               error_count = 0;
	int               request_count = 0;
	int               n_encode = 0;
	int               n_decode = 0;
	int               n_corrected = 0;
	int               n_beyond = 0;

	hamming_sec_codec dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_len_wr_en  (data_len_wr_en),
		.data_len_wr_data(data_len_wr_data),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.word            (word),
		.done            (done),
		.result_word     (result_word),
		.error_position  (error_position),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic is_check_pos(input int p);
		return (p & (p - 1)) == 0;
	endfunction

	// Position of the last data bit for the clamped data length.
	function automatic int code_length(input logic [LEN_W-1:0] len);
		int m;
		int cnt;
		m = len;
		if (m < 1) m = 1;
		if (m > MAX_BITS) m = MAX_BITS;
		cnt = 0;
		for (int p = 1; p <= WORD_W; p++) begin
			if (!is_check_pos(p)) begin
				cnt++;
				if (cnt == m) return p;
			end
		end
		return WORD_W;
	endfunction

	function automatic codec_result_t hamming_predict(input logic f, input logic [WORD_W-1:0] w,
			input logic [LEN_W-1:0] len);
		codec_result_t r;
		logic [WORD_W-1:0] cw;
		int n;
		int k;
		int syn;
		r   = '0;
		r.st = ST_OK;
		n   = code_length(len);
		syn = 0;
		k   = 0;
		if (f == FUNC_ENCODE) begin
			for (int p = 1; p <= n; p++) begin
				if (!is_check_pos(p)) begin
					if (w[k]) begin
						r.word[p-1] = 1'b1;
						syn ^= p;
					end
					k++;
				end
			end
			for (int p = 1; p <= n; p = p * 2) begin
				if ((syn & p) != 0) r.word[p-1] = 1'b1;
			end
			return r;
		end
		cw = w;
		for (int p = 1; p <= n; p++) begin
			if (cw[p-1]) syn ^= p;
		end
		if (syn != 0) begin
			if (syn <= n) begin
				cw[syn-1] = ~cw[syn-1];
				r.st = ST_CORRECTED;
			end else begin
				r.st = ST_BEYOND;
			end
		end
		for (int p = 1; p <= n; p++) begin
			if (!is_check_pos(p)) begin
				r.word[k] = cw[p-1];
				k++;
			end
		end
		r.pos = POS_W'(syn);
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		return WORD_W'({$urandom, $urandom});
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Results are checked against the oldest prediction; new requests are
	// predicted with the length in force when they are accepted.
	always @(posedge clk) begin : result_monitor
		codec_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result strobe with no request outstanding");
				end else begin
					want = expected_q.pop_front();
					if (result_word !== want.word)
						report_mismatch($sformatf("result_word %h, expected %h",
							result_word, want.word));
					if (error_position !== want.pos)
						report_mismatch($sformatf("error_position %0d, expected %0d",
							error_position, want.pos));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.st));
					if (want.st == ST_CORRECTED) n_corrected++;
					if (want.st == ST_BEYOND) n_beyond++;
				end
			end
			if (start && !busy) begin
				expected_q.push_back(hamming_predict(func, word, data_len_model));
				if (func == FUNC_ENCODE) n_encode++;
				else n_decode++;
			end
			if (data_len_wr_en) data_len_model = data_len_wr_data;
		end
	end

	task automatic send_request(input logic f, input logic [WORD_W-1:0] w);
		start <= 1'b1;
		func  <= f;
		word  <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		request_count++;
		if (!no_gaps) begin
			// Each further cycle idles with the same chance, so gaps average
			// about a fifth of the time.
			while ($urandom_range(99) < 22) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	task automatic settle();
		if (start) start <= 1'b0;
		repeat (3) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_data_len(input logic [LEN_W-1:0] v);
		settle();
		data_len_wr_en   <= 1'b1;
		data_len_wr_data <= v;
		cur_len = v;
		@(posedge clk);
		data_len_wr_en <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] encode_for(input logic [WORD_W-1:0] data);
		codec_result_t r;
		r = hamming_predict(FUNC_ENCODE, data, cur_len);
		return r.word;
	endfunction

	function automatic logic [WORD_W-1:0] flip_pos(input logic [WORD_W-1:0] cw, input int p);
		cw[p-1] = ~cw[p-1];
		return cw;
	endfunction

	task automatic test_directed();
		logic [WORD_W-1:0] ones;
		logic [WORD_W-1:0] cw;
		ones = '1;
		// Reset length first: the full 63-bit code.
		send_request(FUNC_ENCODE, '0);
		send_request(FUNC_ENCODE, ones);
		send_request(FUNC_ENCODE, WORD_W'(1));
		send_request(FUNC_ENCODE, WORD_W'(1) << (MAX_BITS - 1));
		send_request(FUNC_DECODE, '0);
		send_request(FUNC_DECODE, ones);
		cw = encode_for(ones);
		send_request(FUNC_DECODE, cw);
		send_request(FUNC_DECODE, flip_pos(cw, 1));
		send_request(FUNC_DECODE, flip_pos(cw, 2));
		send_request(FUNC_DECODE, flip_pos(cw, 3));
		send_request(FUNC_DECODE, flip_pos(cw, WORD_W));
		send_request(FUNC_DECODE, flip_pos(flip_pos(cw, 5), 9));

		// Short code: a double error can point past the last position.
		write_data_len(6'd2);
		send_request(FUNC_DECODE, WORD_W'('b1100));
		send_request(FUNC_DECODE, ones << 5);
		send_request(FUNC_ENCODE, (ones << 2) | WORD_W'(1));
		send_request(FUNC_DECODE, encode_for(WORD_W'(3)) | (ones << 5));

		// Zero length behaves as one data bit.
		write_data_len(6'd0);
		send_request(FUNC_ENCODE, ones);
		send_request(FUNC_DECODE, WORD_W'('b111));
		send_request(FUNC_DECODE, WORD_W'('b001));

		// Lengths above the maximum clamp to it.
		write_data_len(6'd63);
		send_request(FUNC_ENCODE, ones);
		send_request(FUNC_DECODE, flip_pos(encode_for(random_word()), WORD_W));
		write_data_len(6'd58);
		send_request(FUNC_ENCODE, random_word());
		send_request(FUNC_DECODE, flip_pos(encode_for(random_word()), 17));
	endtask

	task automatic test_random_traffic(input int n_requests, input bit steady);
		logic [LEN_W-1:0] extremes[4];
		logic [WORD_W-1:0] cw;
		logic [WORD_W-1:0] above;
		int n;
		int pick;
		extremes = '{6'd0, 6'd1, 6'd57, 6'd63};
		no_gaps = steady;
		for (int i = 0; i < n_requests; i++) begin
			if (i % 50 == 0) begin
				if ($urandom_range(3) == 0) write_data_len(extremes[$urandom_range(3)]);
				else write_data_len(LEN_W'($urandom_range(1, MAX_BITS)));
			end
			n     = code_length(cur_len);
			above = (n >= WORD_W) ? '0 : ('1 << n);
			pick  = $urandom_range(99);
			if (pick < 30) begin
				send_request(FUNC_ENCODE, random_word());
			end else if (pick < 85) begin
				// Mostly clean or single-error codewords, some double errors.
				cw   = encode_for(random_word());
				pick = $urandom_range(9);
				if (pick >= 3) cw = flip_pos(cw, $urandom_range(1, n));
				if (pick >= 8) cw = flip_pos(cw, $urandom_range(1, n));
				if ($urandom_range(1) == 1) cw |= random_word() & above;
				send_request(FUNC_DECODE, cw);
			end else begin
				send_request(FUNC_DECODE, random_word());
			end
		end
		no_gaps = 0;
	endtask

	initial begin
		arst_n           = 1'b0;
		data_len_wr_en   = 1'b0;
		data_len_wr_data = '0;
		start            = 1'b0;
		func             = FUNC_ENCODE;
		word             = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(500, 1'b0);
		test_random_traffic(200, 1'b1);

		settle();
		if (expected_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
		$display("Covered %0d requests: %0d encodes, %0d decodes.",
			request_count, n_encode, n_decode);
		$display("Decodes: %0d single errors corrected, %0d syndromes beyond code length.",
			n_corrected, n_beyond);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
